/* rtl/core/mrt64_pkg.sv */
// Package for the 64-bit Miller-Rabin primality tester.
// Holds the operand width, the witness base table, the sequencer state type
// and the request and response types of the modular unit. No dependencies.
package mrt64_pkg;

	localparam int unsigned WordW  = 64;
	localparam int unsigned NBases = 7;
	localparam int unsigned BaseIdxW = 3;

	typedef logic [WordW-1:0] word_t;

	function automatic word_t witness_base(input logic [BaseIdxW-1:0] idx);
		word_t b;
		begin
			case (idx)
				3'd0:    b = 64'd2;
				3'd1:    b = 64'd325;
				3'd2:    b = 64'd9375;
				3'd3:    b = 64'd28178;
				3'd4:    b = 64'd450775;
				3'd5:    b = 64'd9780504;
				3'd6:    b = 64'd1795265022;
				default: b = 64'd0;
			endcase
			return b;
		end
	endfunction

	// one-hot sequencer states
	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_SPLIT  = 13'b0000000000010,
		S_BASE   = 13'b0000000000100,
		S_RED    = 13'b0000000001000,
		S_PCHK   = 13'b0000000010000,
		S_PMULR  = 13'b0000000100000,
		S_PSQ    = 13'b0000001000000,
		S_PSHIFT = 13'b0000010000000,
		S_XCHK   = 13'b0000100000000,
		S_SQR    = 13'b0001000000000,
		S_SQCHK  = 13'b0010000000000,
		S_NEXT   = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} seq_state_t;

	// command to the shared modular unit
	typedef struct packed {
		logic  start;
		logic  reduce;  // 1: x mod m (shift-subtract); 0: x*y mod m
		word_t x;
		word_t y;
		word_t m;
	} mod_req_t;

	typedef struct packed {
		logic  done;
		word_t r;
	} mod_rsp_t;

endpackage

/* rtl/core/mrt64_modunit.sv */
// Shared modular arithmetic unit: x*y mod m by interleaved shift-add,
// or x mod m by restoring shift-subtract, one bit per cycle.
// Depends on mrt64_pkg.
module mrt64_modunit
	import mrt64_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	localparam int unsigned CntW = $clog2(WordW);

	logic            busy_q;
	logic            done_q;
	logic            red_q;
	logic [CntW-1:0] cnt_q;
	word_t           acc_q;
	word_t           x_q;
	word_t           y_q;
	word_t           m_q;

	// multiply path: acc = 2acc mod m, then + x mod m if bit set
	logic [WordW:0] dbl;
	word_t          dbl_r;
	logic [WordW:0] sum;
	word_t          mul_nxt;
	// reduce path: remainder shift-in of next dividend bit
	logic [WordW:0] rsh;
	word_t          red_nxt;

	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_r   = (dbl >= {1'b0, m_q}) ? word_t'(dbl - {1'b0, m_q}) : acc_q << 1;
		sum     = {1'b0, dbl_r} + {1'b0, x_q};
		if (y_q[WordW-1])
			mul_nxt = (sum >= {1'b0, m_q}) ? word_t'(sum - {1'b0, m_q}) : sum[WordW-1:0];
		else
			mul_nxt = dbl_r;
		rsh     = {acc_q, x_q[WordW-1]};
		red_nxt = (rsh >= {1'b0, m_q}) ? word_t'(rsh - {1'b0, m_q}) : rsh[WordW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(WordW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			x_q   <= req.x;
			y_q   <= req.y;
			m_q   <= req.m;
			red_q <= req.reduce;
		end else if (busy_q) begin
			if (red_q) begin
				acc_q <= red_nxt;
				x_q   <= x_q << 1;
			end else begin
				acc_q <= mul_nxt;
				y_q   <= y_q << 1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.r    = acc_q;

endmodule

/* rtl/core/mrt64_seq.sv */
// Sequencer for the Miller-Rabin rounds: splits n-1, walks the witness bases,
// drives the shared modular unit for base reduction, exponentiation and squaring.
// Depends on mrt64_pkg.
module mrt64_seq
	import mrt64_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  word_t    n,
	output logic     busy,
	output logic     done,
	output logic     verdict,
	output mod_req_t req,
	input  mod_rsp_t rsp
);

	localparam int unsigned SW = $clog2(WordW);

	seq_state_t          st_q;
	word_t               n_q;
	word_t               d_q;
	logic [SW-1:0]       s_q;
	logic [SW-1:0]       r_q;
	word_t               e_q;
	word_t               a_q;
	word_t               x_q;
	logic [BaseIdxW-1:0] k_q;
	logic                prime_q;
	logic                wait_q;
	logic                issue;

	word_t nm1;
	assign nm1 = n_q - 1'b1;

	// launch the modular unit in the states that hand it an operation
	always_comb begin
		case (st_q)
			S_BASE:  issue = 1'b1;
			S_PCHK:  issue = (e_q != '0);
			S_PMULR: issue = rsp.done;
			S_SQCHK: issue = (r_q < s_q);
			default: issue = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			wait_q  <= 1'b0;
			prime_q <= 1'b0;
			req     <= '0;
		end else begin
			req.start <= issue;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						n_q <= n;
						if (n < 64'd2 || !n[0]) begin
							prime_q <= (n == 64'd2);
							st_q    <= S_DONE;
						end else begin
							d_q  <= n - 1'b1;
							s_q  <= '0;
							k_q  <= '0;
							st_q <= S_SPLIT;
						end
					end
				end
				S_SPLIT: begin
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end else begin
						st_q <= S_BASE;
					end
				end
				S_BASE: begin
					{req.reduce, req.x, req.y, req.m} <=
						{1'b1, witness_base(k_q), word_t'(0), n_q};
					st_q  <= S_RED;
				end
				S_RED: begin
					if (rsp.done) begin
						a_q <= rsp.r;
						x_q <= 64'd1;
						e_q <= d_q;
						st_q <= (rsp.r == '0) ? S_NEXT : S_PCHK;
					end
				end
				S_PCHK: begin
					if (e_q == '0) begin
						st_q <= S_XCHK;
					end else if (e_q[0]) begin
						{req.reduce, req.x, req.y, req.m} <= {1'b0, x_q, a_q, n_q};
						st_q <= S_PMULR;
					end else begin
						{req.reduce, req.x, req.y, req.m} <= {1'b0, a_q, a_q, n_q};
						st_q <= S_PSQ;
					end
				end
				S_PMULR: begin
					if (rsp.done) begin
						x_q  <= rsp.r;
						{req.reduce, req.x, req.y, req.m} <= {1'b0, a_q, a_q, n_q};
						st_q <= S_PSQ;
					end
				end
				S_PSQ: begin
					if (rsp.done) begin
						a_q  <= rsp.r;
						st_q <= S_PSHIFT;
					end
				end
				S_PSHIFT: begin
					e_q  <= e_q >> 1;
					st_q <= S_PCHK;
				end
				S_XCHK: begin
					r_q <= SW'(1);
					if (x_q == 64'd1 || x_q == nm1)
						st_q <= S_NEXT;
					else
						st_q <= S_SQCHK;
				end
				S_SQCHK: begin
					if (r_q >= s_q) begin
						prime_q <= 1'b0;
						st_q    <= S_DONE;
					end else begin
						{req.reduce, req.x, req.y, req.m} <= {1'b0, x_q, x_q, n_q};
						st_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (rsp.done) begin
						x_q <= rsp.r;
						r_q <= r_q + 1'b1;
						st_q <= (rsp.r == nm1) ? S_NEXT : S_SQCHK;
					end
				end
				S_NEXT: begin
					if (k_q == BaseIdxW'(NBases - 1)) begin
						prime_q <= 1'b1;
						st_q    <= S_DONE;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= S_BASE;
					end
				end
				S_DONE: begin
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			wait_q <= 1'b0;
		end
	end

	assign busy    = (st_q != S_IDLE) || wait_q;
	assign done    = (st_q == S_DONE);
	assign verdict = prime_q;

endmodule

/* rtl/core/primality_test_64bit.sv */
// Top level of the 64-bit deterministic Miller-Rabin primality tester.
// Depends on mrt64_pkg, mrt64_seq and mrt64_modunit.
//
// One candidate enters per transaction on the s_axis side and one verdict
// leaves on the m_axis side. Candidates below two and even candidates are
// decided without any rounds. Odd candidates run up to seven strong-
// probable-prime rounds (bases 2, 325, 9375, 28178, 450775, 9780504,
// 1795265022) on a single shared modular unit that retires one bit per
// cycle. The block holds s_axis_tready low while a test runs and while a
// verdict waits in the output register; a new candidate is taken once the
// verdict has been handed off.
module primality_test_64bit
	import mrt64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] candidate
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [0] is_prime, [7:1] zero
);

	mod_req_t req;
	mod_rsp_t rsp;
	logic     seq_busy;
	logic     seq_done;
	logic     verdict;
	logic     start;
	logic     out_vld_q;
	logic     out_bit_q;

	// accept only when the sequencer is free and the output slot is empty
	assign s_axis_tready = !seq_busy && !out_vld_q;
	assign start         = s_axis_tvalid && s_axis_tready;

	mrt64_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.n       (s_axis_tdata),
		.busy    (seq_busy),
		.done    (seq_done),
		.verdict (verdict),
		.req     (req),
		.rsp     (rsp)
	);

	mrt64_modunit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// hold the verdict until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_bit_q <= 1'b0;
		end else begin
			if (seq_done) begin
				out_vld_q <= 1'b1;
				out_bit_q <= verdict;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'd0, out_bit_q};

endmodule
